// ===== rtl/clf_pkg.sv =====
// ----------------------------------------------------------------------------
// clf_pkg
// shared types, constants and helper functions of the console line formatter
// ----------------------------------------------------------------------------
package clf_pkg;

    // record bookkeeping
    localparam int LINE_OVERHEAD = 10;
    localparam int MAX_COLUMNS   = 255;

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_COLUMN_LIMIT = 2'd0;
    localparam logic [1:0] REG_TAB_STEP     = 2'd1;
    localparam logic [1:0] REG_BUFFER_ROOM  = 2'd2;

    localparam logic [7:0]  RST_COLUMN_LIMIT = 8'd80;
    localparam logic [7:0]  RST_TAB_STEP     = 8'd8;
    localparam logic [15:0] RST_BUFFER_ROOM  = 16'd4000;

    // control characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    typedef enum logic [2:0] {
        K_PUT     = 3'd0,
        K_FILL    = 3'd1,
        K_CLOSE   = 3'd2,
        K_ALARM   = 3'd3,
        K_FULL    = 3'd4,
        K_FLUSHED = 3'd5,
        K_EMPTY   = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0]  column_limit;
        logic [7:0]  tab_step;
        logic [15:0] buffer_room;
    } cfg_t;

    typedef struct packed {
        logic        is_open;
        logic [7:0]  len;
        logic [15:0] used;
        logic [15:0] count;
        logic [15:0] sum;
    } line_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  column;
        logic [7:0]  amount;
        line_state_t snap;
    } entry_t;

    typedef struct packed {
        logic [15:0] lines;
        logic [15:0] chars;
        logic [15:0] room;
    } totals_t;

    function automatic logic [15:0] f_sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [7:0] f_limit(input cfg_t cfg);
        logic [7:0] lim;
        lim = (cfg.column_limit == 8'd0) ? 8'd1 : cfg.column_limit;
        if (lim > 8'(MAX_COLUMNS))
            lim = 8'(MAX_COLUMNS);
        return lim;
    endfunction

    function automatic logic [7:0] f_step(input cfg_t cfg);
        return (cfg.tab_step == 8'd0) ? 8'd1 : cfg.tab_step;
    endfunction

    function automatic logic [15:0] f_avail(input logic [15:0] room, input logic [15:0] used);
        return (room > used) ? room - used : 16'd0;
    endfunction

    // room for a new line of the given column need
    function automatic logic f_fits(input line_state_t s, input logic [15:0] room,
                                    input logic [7:0] need);
        return 17'(f_avail(room, s.used)) >= 17'(LINE_OVERHEAD) + 17'(need);
    endfunction

    function automatic line_state_t f_close(input line_state_t s);
        line_state_t r;
        r.is_open = 1'b0;
        r.len     = 8'd0;
        r.used    = f_sat16(17'(s.used) + 17'(LINE_OVERHEAD) + 17'(s.len));
        r.count   = f_sat16(17'(s.count) + 17'd1);
        r.sum     = f_sat16(17'(s.sum) + 17'(s.len));
        return r;
    endfunction

    function automatic entry_t f_entry(input kind_t k, input logic [7:0] col,
                                       input logic [7:0] amt, input line_state_t s);
        entry_t e;
        e.kind   = k;
        e.column = col;
        e.amount = amt;
        e.snap   = s;
        return e;
    endfunction

    function automatic totals_t f_totals(input line_state_t s, input logic [15:0] room);
        totals_t     t;
        logic [16:0] open_use;
        logic [15:0] av;
        open_use = s.is_open ? 17'(LINE_OVERHEAD) + 17'(s.len) : 17'd0;
        av       = f_avail(room, s.used);
        t.lines  = s.count;
        t.chars  = f_sat16(17'(s.sum) + (s.is_open ? 17'(s.len) : 17'd0));
        t.room   = (17'(av) > open_use) ? 16'(17'(av) - open_use) : 16'd0;
        return t;
    endfunction

endpackage

// ===== rtl/clf_regs.sv =====
// ----------------------------------------------------------------------------
// clf_regs
// configuration registers behind a simple apb-style port
// ----------------------------------------------------------------------------
module clf_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [clf_pkg::CFG_AW-1:0]  paddr,
    input  logic [clf_pkg::CFG_DW-1:0]  pwdata,
    output logic [clf_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output clf_pkg::cfg_t               cfg
);
    import clf_pkg::*;

    logic [7:0]  column_limit_reg;
    logic [7:0]  tab_step_reg;
    logic [15:0] buffer_room_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign reg_index = paddr[CFG_AW-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_limit_reg <= RST_COLUMN_LIMIT;
            tab_step_reg     <= RST_TAB_STEP;
            buffer_room_reg  <= RST_BUFFER_ROOM;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_COLUMN_LIMIT: column_limit_reg <= pwdata[7:0];
                REG_TAB_STEP:     tab_step_reg     <= pwdata[7:0];
                REG_BUFFER_ROOM:  buffer_room_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_COLUMN_LIMIT: prdata = CFG_DW'(column_limit_reg);
            REG_TAB_STEP:     prdata = CFG_DW'(tab_step_reg);
            REG_BUFFER_ROOM:  prdata = CFG_DW'(buffer_room_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.column_limit = column_limit_reg;
    assign cfg.tab_step     = tab_step_reg;
    assign cfg.buffer_room  = buffer_room_reg;

endmodule

// ===== rtl/clf_rem.sv =====
// ----------------------------------------------------------------------------
// clf_rem
// shared remainder unit, restoring division one dividend bit per cycle
// ----------------------------------------------------------------------------
module clf_rem (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] remainder
);
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] dvd_reg, dvd_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] rem_reg, rem_next;
    logic [8:0] trial;

    assign trial = {rem_reg, dvd_reg[7]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = 8'd0;
        end
        else if (busy_reg)
        begin
            // divisor is never zero, so a kept trial always fits in 8 bits
            rem_next = (trial >= 9'(div_reg)) ? 8'(trial - 9'(div_reg)) : trial[7:0];
            dvd_next = {dvd_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/clf_step.sv =====
// ----------------------------------------------------------------------------
// clf_step
// per-item line bookkeeping, yields the new state and up to two records
// ----------------------------------------------------------------------------
module clf_step (
    input  clf_pkg::line_state_t st,
    input  logic                 skipping,
    input  logic                 op,
    input  logic [7:0]           char_code,
    input  logic                 eom,
    input  clf_pkg::cfg_t        cfg,
    input  logic [7:0]           rem,
    output clf_pkg::line_state_t st_next,
    output logic                 skip_next,
    output clf_pkg::entry_t      ent0,
    output clf_pkg::entry_t      ent1,
    output logic [1:0]           count
);
    import clf_pkg::*;

    always_comb
    begin
        line_state_t s;
        entry_t      e [2];
        logic [1:0]  n;
        logic        rej;
        logic [7:0]  lim;
        logic [7:0]  start;
        logic [7:0]  ind;
        logic [7:0]  clen;
        logic [8:0]  nxt;
        logic [15:0] room;

        s         = st;
        e[0]      = '0;
        e[1]      = '0;
        n         = 2'd0;
        rej       = 1'b0;
        lim       = f_limit(cfg);
        room      = cfg.buffer_room;
        start     = 8'd0;
        ind       = 8'd0;
        clen      = 8'd0;
        nxt       = 9'd0;
        skip_next = skipping;

        if (op)
        begin
            if (s.is_open)
            begin
                clen = s.len;
                s = f_close(s);
                e[n[0]] = f_entry(K_CLOSE, 8'd0, clen, s);
                n = n + 2'd1;
            end
            e[n[0]] = f_entry((s.count == 16'd0) ? K_EMPTY : K_FLUSHED, 8'd0, 8'd0, s);
            n = n + 2'd1;
            s = '0;
        end
        else if (skipping)
        begin
            if (eom)
                skip_next = 1'b0;
        end
        else
        begin
            case (char_code)
                CH_LF:
                begin
                    if (!s.is_open && !f_fits(s, room, 8'd0))
                        rej = 1'b1;
                    else
                    begin
                        s.is_open = 1'b1;
                        clen = s.len;
                        s = f_close(s);
                        e[n[0]] = f_entry(K_CLOSE, 8'd0, clen, s);
                        n = n + 2'd1;
                    end
                end
                CH_BEL:
                begin
                    e[n[0]] = f_entry(K_ALARM, 8'd0, 8'd0, s);
                    n = n + 2'd1;
                end
                CH_TAB:
                begin
                    if (!s.is_open && !f_fits(s, room, lim))
                        rej = 1'b1;
                    else
                    begin
                        s.is_open = 1'b1;
                        start = s.len;
                        // next stop strictly past the start column
                        nxt = 9'(start) - 9'(rem) + 9'(f_step(cfg));
                        if (start >= lim)
                            s.len = start;
                        else if (nxt > 9'(lim))
                            s.len = lim;
                        else
                            s.len = nxt[7:0];
                        e[n[0]] = f_entry(K_FILL, start, s.len - start, s);
                        n = n + 2'd1;
                    end
                end
                CH_VT, CH_FF:
                begin
                    if (s.is_open)
                    begin
                        ind  = (s.len < lim) ? s.len : lim - 8'd1;
                        clen = s.len;
                        s = f_close(s);
                        e[n[0]] = f_entry(K_CLOSE, 8'd0, clen, s);
                        n = n + 2'd1;
                        if (!f_fits(s, room, lim))
                            rej = 1'b1;
                        else
                        begin
                            s.is_open = 1'b1;
                            s.len     = ind;
                            e[n[0]] = f_entry(K_FILL, 8'd0, ind, s);
                            n = n + 2'd1;
                        end
                    end
                    else if (!f_fits(s, room, lim))
                        rej = 1'b1;
                    else
                    begin
                        // empty line opened and closed at once
                        s.is_open = 1'b1;
                        s.len     = 8'd0;
                        s = f_close(s);
                        e[n[0]] = f_entry(K_CLOSE, 8'd0, 8'd0, s);
                        n = n + 2'd1;
                    end
                end
                CH_BS:
                begin
                    if (s.is_open && s.len != 8'd0)
                        s.len = s.len - 8'd1;
                end
                CH_NUL:
                begin
                    if (s.is_open)
                    begin
                        clen = s.len;
                        s = f_close(s);
                        e[n[0]] = f_entry(K_CLOSE, 8'd0, clen, s);
                        n = n + 2'd1;
                    end
                    if (!eom)
                        skip_next = 1'b1;
                end
                default:
                begin
                    if ((char_code >= 8'h20 && char_code <= 8'h7E) || char_code >= 8'hA0)
                    begin
                        if (!s.is_open && !f_fits(s, room, lim))
                            rej = 1'b1;
                        else
                        begin
                            s.is_open = 1'b1;
                            e[n[0]] = f_entry(K_PUT, s.len, char_code, s);
                            n = n + 2'd1;
                            s.len = s.len + 8'd1;
                        end
                    end
                end
            endcase

            if (rej)
            begin
                e[n[0]] = f_entry(K_FULL, 8'd0, char_code, s);
                n = n + 2'd1;
            end
            else if (s.is_open && s.len >= lim)
            begin
                clen = s.len;
                s = f_close(s);
                e[n[0]] = f_entry(K_CLOSE, 8'd0, clen, s);
                n = n + 2'd1;
            end
        end

        st_next = s;
        ent0    = e[0];
        ent1    = e[1];
        count   = n;
    end

endmodule

// ===== rtl/console_line_formatter_top.sv =====
// ----------------------------------------------------------------------------
// console_line_formatter_top
// turns console characters into line records inside a buffer of limited room
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  char      in         char_valid / char_ready   op, char_code, end_of_message
//  rec       out        rec_valid / rec_ready     kind, column, amount,
//                                                 lines_total, chars_total,
//                                                 room_left, last
//  cfg       in         apb psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  a tab first waits in S_DIV while the shared remainder unit works (one dividend
//  bit per cycle) until the sequencer sees it finish, then takes the step state
//  and the output register; every other word goes from accept straight to the
//  step state and then into the output register
//  records leave one per cycle while rec_ready allows, through an output register,
//  so the next word is accepted while the last record still waits for rec_ready
//  reset clears the line state, the counters, skip mode and the sequencer;
//  configuration registers return to their documented defaults
// ----------------------------------------------------------------------------
module console_line_formatter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [clf_pkg::CFG_AW-1:0]  paddr,
    input  logic [clf_pkg::CFG_DW-1:0]  pwdata,
    output logic [clf_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    // character words
    input  logic                        char_valid,
    output logic                        char_ready,
    input  logic                        op,
    input  logic [7:0]                  char_code,
    input  logic                        end_of_message,
    // record words
    output logic                        rec_valid,
    input  logic                        rec_ready,
    output logic [2:0]                  kind,
    output logic [7:0]                  column,
    output logic [7:0]                  amount,
    output logic [15:0]                 lines_total,
    output logic [15:0]                 chars_total,
    output logic [15:0]                 room_left,
    output logic                        last
);
    import clf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EXEC = 4'b0100,
        S_SEND = 4'b1000
    } seq_state_t;

    cfg_t        cfg;

    seq_state_t  state_reg, state_next;
    line_state_t st_reg, st_next;
    logic        skip_reg, skip_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        idx_reg, idx_next;
    logic        rec_valid_reg, rec_valid_next;

    // held word
    logic        op_reg;
    logic [7:0]  code_reg;
    logic        eom_reg;

    // queued records of the current word
    entry_t      ent_reg [2];

    // output register payload
    kind_t       kind_reg;
    logic [7:0]  column_reg;
    logic [7:0]  amount_reg;
    logic [15:0] lines_reg;
    logic [15:0] chars_reg;
    logic [15:0] room_reg;
    logic        last_reg;

    // step outputs
    line_state_t step_st;
    logic        step_skip;
    entry_t      step_ent0;
    entry_t      step_ent1;
    logic [1:0]  step_cnt;

    logic        rem_done;
    logic [7:0]  rem_value;

    logic        char_fire;
    logic        tab_go;
    logic        send_fire;
    entry_t      send_ent;
    totals_t     send_tot;
    logic        send_last;

    // ------------------------------------------------------------------------
    // submodules
    // ------------------------------------------------------------------------
    clf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // remainder of the current column by the tab step, only for tabs
    clf_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (char_fire && tab_go),
        .dividend  (st_reg.len),
        .divisor   (f_step(cfg)),
        .done      (rem_done),
        .remainder (rem_value)
    );

    clf_step u_step (
        .st        (st_reg),
        .skipping  (skip_reg),
        .op        (op_reg),
        .char_code (code_reg),
        .eom       (eom_reg),
        .cfg       (cfg),
        .rem       (rem_value),
        .st_next   (step_st),
        .skip_next (step_skip),
        .ent0      (step_ent0),
        .ent1      (step_ent1),
        .count     (step_cnt)
    );

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    assign char_ready = (state_reg == S_IDLE);
    assign char_fire  = char_valid && char_ready;
    // a tab only needs the remainder when it is actually processed
    assign tab_go     = !op && !skip_reg && (char_code == CH_TAB);

    // output register free or being emptied this cycle
    assign send_fire  = (state_reg == S_SEND) && (!rec_valid_reg || rec_ready);
    assign send_ent   = ent_reg[idx_reg];
    assign send_tot   = f_totals(send_ent.snap, cfg.buffer_room);
    assign send_last  = (2'(idx_reg) + 2'd1 == cnt_reg);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        skip_next      = skip_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rec_valid_next = rec_valid_reg;

        if (rec_valid_reg && rec_ready)
            rec_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (char_fire)
                    state_next = tab_go ? S_DIV : S_EXEC;
            end
            S_DIV:
            begin
                if (rem_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // commit line state, queue the records
                st_next   = step_st;
                skip_next = step_skip;
                cnt_next  = step_cnt;
                idx_next  = 1'b0;
                state_next = (step_cnt == 2'd0) ? S_IDLE : S_SEND;
            end
            S_SEND:
            begin
                if (send_fire)
                begin
                    rec_valid_next = 1'b1;
                    if (send_last)
                        state_next = S_IDLE;
                    else
                        idx_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= '0;
            skip_reg      <= 1'b0;
            cnt_reg       <= 2'd0;
            idx_reg       <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            skip_reg      <= skip_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (char_fire)
        begin
            op_reg   <= op;
            code_reg <= char_code;
            eom_reg  <= end_of_message;
        end
        if (state_reg == S_EXEC)
        begin
            ent_reg[0] <= step_ent0;
            ent_reg[1] <= step_ent1;
        end
        if (send_fire)
        begin
            kind_reg   <= send_ent.kind;
            column_reg <= send_ent.column;
            amount_reg <= send_ent.amount;
            lines_reg  <= send_tot.lines;
            chars_reg  <= send_tot.chars;
            room_reg   <= send_tot.room;
            last_reg   <= send_last;
        end
    end

    assign rec_valid   = rec_valid_reg;
    assign kind        = kind_reg;
    assign column      = column_reg;
    assign amount      = amount_reg;
    assign lines_total = lines_reg;
    assign chars_total = chars_reg;
    assign room_left   = room_reg;
    assign last        = last_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the remainder unit only finishes while the sequencer waits for it
    a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> (state_reg == S_DIV))
        else $error("remainder finished outside the wait state");

    // sending always has at least one queued record
    a_send_has_records: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |-> (cnt_reg != 2'd0))
        else $error("send state with an empty record queue");

    // a closed line always has zero length
    a_closed_line_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.is_open |-> (st_reg.len == 8'd0))
        else $error("closed line holds a length");

    // a flush leaves skip mode untouched
    a_flush_keeps_skip: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && op_reg) |=> (skip_reg == $past(skip_reg)))
        else $error("flush changed skip mode");

endmodule
